// ===== rtl/blol_pkg.sv =====
// shared types for the bounded ordered list
`default_nettype none

package blol_pkg;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AFTER = 3'd2,
    CMD_SEARCH    = 3'd3,
    CMD_DEL_VALUE = 3'd4,
    CMD_DEL_FRONT = 3'd5,
    CMD_DEL_BACK  = 3'd6,
    CMD_NOP       = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REPORT
  } state_e;

  typedef enum logic [2:0] {
    SH_HOLD,
    SH_INS_FRONT,
    SH_INS_BACK,
    SH_INS_AFTER,
    SH_DEL_VALUE,
    SH_DEL_FRONT,
    SH_DEL_BACK
  } shift_e;

  typedef struct packed {
    logic   compare;
    shift_e shift;
  } cell_ctl_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic seen_in;
    logic seen_out;
  } link_t;

  localparam int unsigned HitBits = 4;

endpackage

`default_nettype wire

// ===== rtl/blol_cell.sv =====
// one storage cell of the list chain
`default_nettype none

module blol_cell #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned IDX        = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  blol_pkg::cell_ctl_t         ctl_i,
  input  logic [VALUE_BITS-1:0]       operand_i,
  input  logic [VALUE_BITS-1:0]       ins_value_i,
  input  blol_pkg::link_t             left_i,
  input  logic [VALUE_BITS-1:0]       left_value_i,
  input  logic                        right_valid_i,
  input  logic [VALUE_BITS-1:0]       right_value_i,
  input  logic [blol_pkg::HitBits-1:0] hit_i,
  input  logic [VALUE_BITS-1:0]       back_i,
  output blol_pkg::link_t             link_o,
  output logic [VALUE_BITS-1:0]       value_o,
  output logic [blol_pkg::HitBits-1:0] hit_o,
  output logic [VALUE_BITS-1:0]       back_o
);
  import blol_pkg::*;

  localparam logic [HitBits-1:0] IdxLow = HitBits'(IDX % (2 ** HitBits));

  logic [VALUE_BITS-1:0] value_q, value_d;
  logic                  valid_q, valid_d;
  logic                  match_q, match_d;
  logic                  first;
  logic                  seen_out;

  assign first    = match_q & ~left_i.seen_out;
  assign seen_out = left_i.seen_out | match_q;

  assign link_o.valid    = valid_q;
  assign link_o.first    = first;
  assign link_o.seen_in  = left_i.seen_out;
  assign link_o.seen_out = seen_out;
  assign value_o         = value_q;

  assign hit_o  = hit_i | (first ? IdxLow : '0);
  assign back_o = back_i | ((valid_q & ~right_valid_i) ? value_q : '0);

  assign match_d = ctl_i.compare ? (valid_q && (value_q == operand_i)) : match_q;

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    case (ctl_i.shift)
      SH_INS_FRONT: begin
        value_d = left_value_i;
        valid_d = left_i.valid;
      end
      SH_INS_BACK: begin
        if (left_i.valid && !valid_q) begin
          value_d = ins_value_i;
        end
        valid_d = left_i.valid;
      end
      SH_INS_AFTER: begin
        if (left_i.first) begin
          value_d = ins_value_i;
        end else if (left_i.seen_in) begin
          value_d = left_value_i;
        end
        valid_d = left_i.valid;
      end
      SH_DEL_VALUE: begin
        if (seen_out) begin
          value_d = right_value_i;
        end
        valid_d = right_valid_i;
      end
      SH_DEL_FRONT: begin
        value_d = right_value_i;
        valid_d = right_valid_i;
      end
      SH_DEL_BACK: begin
        valid_d = right_valid_i;
      end
      default: begin
        value_d = value_q;
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

// ===== rtl/blol_ctrl.sv =====
// command sequencer, occupancy counter and result register
`default_nettype none

module blol_ctrl #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   cmd_i,
  input  logic [31:0]                  value_i,
  input  logic [31:0]                  key_i,
  output blol_pkg::cell_ctl_t          cell_ctl_o,
  output logic [VALUE_BITS-1:0]        operand_o,
  output logic [VALUE_BITS-1:0]        ins_value_o,
  input  logic                         found_i,
  input  logic [blol_pkg::HitBits-1:0] hit_i,
  input  logic [VALUE_BITS-1:0]        front_i,
  input  logic [VALUE_BITS-1:0]        back_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [3:0]                   hit_position_o,
  output logic [4:0]                   count_o,
  output logic [31:0]                  front_value_o,
  output logic [31:0]                  back_value_o
);
  import blol_pkg::*;

  localparam int unsigned CntBits = $clog2(CAPACITY + 1);
  localparam logic [CntBits-1:0] CntFull = CntBits'(CAPACITY);

  state_e                state_q, state_d;
  cmd_e                  cmd_q, cmd_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  logic [CntBits-1:0]    count_q, count_d;
  status_e               res_status_q, res_status_d;
  logic [HitBits-1:0]    res_hit_q, res_hit_d;
  logic                  out_valid_q, out_valid_d;
  logic [1:0]            out_status_q, out_status_d;
  logic [3:0]            out_hit_q, out_hit_d;
  logic [4:0]            out_count_q, out_count_d;
  logic [31:0]           out_front_q, out_front_d;
  logic [31:0]           out_back_q, out_back_d;
  logic                  accept;
  logic                  full;
  logic                  empty;
  cmd_e                  cmd_in;

  assign cmd_in      = cmd_e'(cmd_i);
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign full        = (count_q == CntFull);
  assign empty       = (count_q == '0);
  assign operand_o   = (cmd_in == CMD_INS_AFTER) ? VALUE_BITS'(key_i) : VALUE_BITS'(value_i);
  assign ins_value_o = value_q;

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign hit_position_o = out_hit_q;
  assign count_o        = out_count_q;
  assign front_value_o  = out_front_q;
  assign back_value_o   = out_back_q;

  always_comb begin
    state_d            = state_q;
    cmd_d              = cmd_q;
    value_d            = value_q;
    count_d            = count_q;
    res_status_d       = res_status_q;
    res_hit_d          = res_hit_q;
    out_valid_d        = out_valid_q;
    out_status_d       = out_status_q;
    out_hit_d          = out_hit_q;
    out_count_d        = out_count_q;
    out_front_d        = out_front_q;
    out_back_d         = out_back_q;
    cell_ctl_o.compare = accept;
    cell_ctl_o.shift   = SH_HOLD;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d   = cmd_in;
          value_d = VALUE_BITS'(value_i);
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_d = ST_OK;
        res_hit_d    = '0;
        case (cmd_q)
          CMD_INS_FRONT: begin
            if (full) begin
              res_status_d = ST_FULL;
            end else begin
              cell_ctl_o.shift = SH_INS_FRONT;
              count_d          = count_q + 1'b1;
            end
          end
          CMD_INS_BACK: begin
            if (full) begin
              res_status_d = ST_FULL;
            end else begin
              cell_ctl_o.shift = SH_INS_BACK;
              count_d          = count_q + 1'b1;
            end
          end
          CMD_INS_AFTER: begin
            if (full) begin
              res_status_d = ST_FULL;
            end else if (!found_i) begin
              res_status_d = ST_NOT_FOUND;
            end else begin
              cell_ctl_o.shift = SH_INS_AFTER;
              count_d          = count_q + 1'b1;
            end
          end
          CMD_SEARCH: begin
            if (!found_i) begin
              res_status_d = ST_NOT_FOUND;
            end else begin
              res_hit_d = hit_i;
            end
          end
          CMD_DEL_VALUE: begin
            if (empty) begin
              res_status_d = ST_EMPTY;
            end else if (!found_i) begin
              res_status_d = ST_NOT_FOUND;
            end else begin
              res_hit_d        = hit_i;
              cell_ctl_o.shift = SH_DEL_VALUE;
              count_d          = count_q - 1'b1;
            end
          end
          CMD_DEL_FRONT: begin
            if (empty) begin
              res_status_d = ST_EMPTY;
            end else begin
              cell_ctl_o.shift = SH_DEL_FRONT;
              count_d          = count_q - 1'b1;
            end
          end
          CMD_DEL_BACK: begin
            if (empty) begin
              res_status_d = ST_EMPTY;
            end else begin
              cell_ctl_o.shift = SH_DEL_BACK;
              count_d          = count_q - 1'b1;
            end
          end
          default: begin
            res_status_d = ST_OK;
          end
        endcase
        state_d = S_REPORT;
      end
      S_REPORT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_hit_d    = res_hit_q;
          out_count_d  = 5'(count_q);
          out_front_d  = 32'(front_i);
          out_back_d   = 32'(back_i);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    value_q      <= value_d;
    res_status_q <= res_status_d;
    res_hit_q    <= res_hit_d;
    out_status_q <= out_status_d;
    out_hit_q    <= out_hit_d;
    out_count_q  <= out_count_d;
    out_front_q  <= out_front_d;
    out_back_q   <= out_back_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("occupancy above capacity");

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC))
    else $error("accepted request did not start execution");

  a_result_from_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_REPORT))
    else $error("result loaded outside report phase");

  a_count_only_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(state_q == S_EXEC))
    else $error("occupancy changed outside execution");

endmodule

`default_nettype wire

// ===== rtl/bounded_ordered_list.sv =====
// bounded ordered list built from a chain of storage cells
// sequence: cells register their compare at the accepting edge, shift on the next edge,
//   and the result is registered from the report state once the output register is free
// requests do not overlap: a new one is accepted only after the previous result is registered
// reset: list empty, no result pending; stored values are undefined until written
`default_nettype none

module bounded_ordered_list #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [31:0] value_i,
  input  logic [31:0] key_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [3:0]  hit_position_o,
  output logic [4:0]  count_o,
  output logic [31:0] front_value_o,
  output logic [31:0] back_value_o
);
  import blol_pkg::*;

  cell_ctl_t             cell_ctl;
  logic [VALUE_BITS-1:0] operand;
  logic [VALUE_BITS-1:0] ins_value;
  link_t                 links [CAPACITY];
  logic [VALUE_BITS-1:0] values [CAPACITY];
  logic [HitBits-1:0]    hit_chain [CAPACITY+1];
  logic [VALUE_BITS-1:0] back_chain [CAPACITY+1];
  logic [VALUE_BITS-1:0] front;

  assign hit_chain[0]  = '0;
  assign back_chain[0] = '0;
  assign front         = links[0].valid ? values[0] : '0;

  blol_ctrl #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .value_i        (value_i),
    .key_i          (key_i),
    .cell_ctl_o     (cell_ctl),
    .operand_o      (operand),
    .ins_value_o    (ins_value),
    .found_i        (links[CAPACITY-1].seen_out),
    .hit_i          (hit_chain[CAPACITY]),
    .front_i        (front),
    .back_i         (back_chain[CAPACITY]),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .hit_position_o (hit_position_o),
    .count_o        (count_o),
    .front_value_o  (front_value_o),
    .back_value_o   (back_value_o)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    link_t                 left;
    logic [VALUE_BITS-1:0] left_value;
    logic                  right_valid;
    logic [VALUE_BITS-1:0] right_value;

    if (i == 0) begin : g_head
      assign left.valid    = 1'b1;
      assign left.first    = 1'b0;
      assign left.seen_in  = 1'b0;
      assign left.seen_out = 1'b0;
      assign left_value    = ins_value;
    end else begin : g_body
      assign left       = links[i-1];
      assign left_value = values[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_value = '0;
    end else begin : g_next
      assign right_valid = links[i+1].valid;
      assign right_value = values[i+1];
    end

    blol_cell #(
      .VALUE_BITS (VALUE_BITS),
      .IDX        (i)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (cell_ctl),
      .operand_i     (operand),
      .ins_value_i   (ins_value),
      .left_i        (left),
      .left_value_i  (left_value),
      .right_valid_i (right_valid),
      .right_value_i (right_value),
      .hit_i         (hit_chain[i]),
      .back_i        (back_chain[i]),
      .link_o        (links[i]),
      .value_o       (values[i]),
      .hit_o         (hit_chain[i+1]),
      .back_o        (back_chain[i+1])
    );
  end

endmodule

`default_nettype wire

// ===== tb/sv/bounded_ordered_list_tb.sv =====
// testbench for the bounded ordered list: directed and random requests checked against a shadow list
`timescale 1ns / 1ps

module bounded_ordered_list_tb;
  import blol_pkg::*;

  localparam int unsigned Capacity = 16;
  localparam int QuietLimit = 3000;
  localparam int ItemsPerPhase = 280;

  typedef struct {
    status_e     status;
    logic [3:0]  hit;
    logic [4:0]  count;
    logic [31:0] front;
    logic [31:0] back;
  } answer_t;

  class list_shadow;
    logic [31:0] slots [Capacity];
    int fill;
    int mismatches;
    answer_t expected_answers [$];

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    function int locate(logic [31:0] v);
      for (int i = 0; i < fill; i++) begin
        if (slots[i] == v) return i;
      end
      return fill;
    endfunction

    function void place(int pos, logic [31:0] v);
      for (int i = fill; i > pos; i--) slots[i] = slots[i-1];
      slots[pos] = v;
      fill++;
    endfunction

    function void drop(int pos);
      for (int i = pos; i + 1 < fill; i++) slots[i] = slots[i+1];
      fill--;
    endfunction

    function void note_request(cmd_e cmd, logic [31:0] value, logic [31:0] key);
      answer_t a;
      int idx;
      a.status = ST_OK;
      a.hit = '0;
      case (cmd)
        CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AFTER: begin
          if (fill == Capacity) begin
            a.status = ST_FULL;
          end else if (cmd == CMD_INS_FRONT) begin
            place(0, value);
          end else if (cmd == CMD_INS_BACK) begin
            place(fill, value);
          end else begin
            idx = locate(key);
            if (idx == fill) a.status = ST_NOT_FOUND;
            else place(idx + 1, value);
          end
        end
        CMD_SEARCH: begin
          idx = locate(value);
          if (idx == fill) a.status = ST_NOT_FOUND;
          else a.hit = 4'(idx);
        end
        CMD_DEL_VALUE: begin
          if (fill == 0) begin
            a.status = ST_EMPTY;
          end else begin
            idx = locate(value);
            if (idx == fill) begin
              a.status = ST_NOT_FOUND;
            end else begin
              a.hit = 4'(idx);
              drop(idx);
            end
          end
        end
        CMD_DEL_FRONT: begin
          if (fill == 0) a.status = ST_EMPTY;
          else drop(0);
        end
        CMD_DEL_BACK: begin
          if (fill == 0) a.status = ST_EMPTY;
          else fill--;
        end
        default: ;
      endcase
      a.count = 5'(fill);
      a.front = (fill > 0) ? slots[0] : 32'h0;
      a.back  = (fill > 0) ? slots[fill-1] : 32'h0;
      expected_answers.push_back(a);
    endfunction

    function void check_answer(logic [1:0] status, logic [3:0] hit, logic [4:0] count,
                               logic [31:0] front, logic [31:0] back);
      answer_t a;
      if (expected_answers.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
        return;
      end
      a = expected_answers.pop_front();
      if (status !== a.status) begin
        $error("status: expected %0d, got %0d", a.status, status);
        mismatches++;
      end
      if (hit !== a.hit) begin
        $error("hit_position: expected %0d, got %0d", a.hit, hit);
        mismatches++;
      end
      if (count !== a.count) begin
        $error("count: expected %0d, got %0d", a.count, count);
        mismatches++;
      end
      if (front !== a.front) begin
        $error("front_value: expected %h, got %h", a.front, front);
        mismatches++;
      end
      if (back !== a.back) begin
        $error("back_value: expected %h, got %h", a.back, back);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  cmd_i;
  logic [31:0] value_i;
  logic [31:0] key_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [3:0]  hit_position_o;
  logic [4:0]  count_o;
  logic [31:0] front_value_o;
  logic [31:0] back_value_o;

  list_shadow book;
  int idle_pct;
  int stall_pct;
  int hold_left;
  bit hold_request;
  int quiet_cycles;
  bit filling;

  bounded_ordered_list #(
    .CAPACITY  (Capacity),
    .VALUE_BITS(32)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .value_i       (value_i),
    .key_i         (key_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .hit_position_o(hit_position_o),
    .count_o       (count_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("[bounded_ordered_list] ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        book.check_answer(status_o, hit_position_o, count_o, front_value_o, back_value_o);
      end
      if (hold_request) begin
        hold_left = 400;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_request(input cmd_e cmd, input logic [31:0] value,
                              input logic [31:0] key);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    value_i    <= value;
    key_i      <= key;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    book.note_request(cmd, value, key);
  endtask

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 45 && book.fill > 0) return book.slots[$urandom_range(book.fill - 1)];
    if (r < 85) begin
      case ($urandom_range(5))
        0: return 32'h0000_0000;
        1: return 32'h0000_0001;
        2: return 32'hFFFF_FFFF;
        3: return 32'h8000_0000;
        4: return 32'h7FFF_FFFF;
        default: return 32'($urandom_range(15));
      endcase
    end
    return $urandom();
  endfunction

  task automatic send_random_request();
    int r;
    cmd_e cmd;
    if (book.fill == Capacity) filling = 1'b0;
    else if (book.fill == 0) filling = 1'b1;
    else if ($urandom_range(99) < 2) filling = ~filling;
    r = $urandom_range(99);
    if (r == 0) cmd = CMD_NOP;
    else if (filling) begin
      if (r < 55) cmd = cmd_e'($urandom_range(2));
      else if (r < 70) cmd = CMD_SEARCH;
      else if (r < 80) cmd = CMD_DEL_VALUE;
      else if (r < 90) cmd = CMD_DEL_FRONT;
      else cmd = CMD_DEL_BACK;
    end else begin
      if (r < 25) cmd = cmd_e'($urandom_range(2));
      else if (r < 40) cmd = CMD_SEARCH;
      else if (r < 65) cmd = CMD_DEL_VALUE;
      else if (r < 82) cmd = CMD_DEL_FRONT;
      else cmd = CMD_DEL_BACK;
    end
    send_request(cmd, pick_value(), pick_value());
  endtask

  initial begin
    book = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = CMD_NOP;
    value_i = '0;
    key_i = '0;
    out_ready_i = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    hold_request = 1'b0;
    quiet_cycles = 0;
    filling = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list corner cases
    send_request(CMD_SEARCH, 32'h0, 32'h0);
    send_request(CMD_DEL_VALUE, 32'h0, 32'h0);
    send_request(CMD_DEL_FRONT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_DEL_BACK, 32'h0, 32'h0);
    send_request(CMD_INS_AFTER, 32'h1, 32'h0);
    send_request(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    send_request(CMD_INS_BACK, 32'h0, 32'hFFFF_FFFF);
    send_request(CMD_INS_FRONT, 32'hFFFF_FFFF, 32'h0);
    send_request(CMD_INS_AFTER, 32'h5A5A_5A5A, 32'h0);
    send_request(CMD_INS_AFTER, 32'h1, 32'h1234_5678);
    send_request(CMD_SEARCH, 32'h5A5A_5A5A, 32'h0);

    // fill up, with duplicates
    for (int i = 0; i < 13; i++) begin
      case (i % 3)
        0: send_request(CMD_INS_BACK, 32'(i), 32'h0);
        1: send_request(CMD_INS_FRONT, ~32'(i), 32'h0);
        default: send_request(CMD_INS_AFTER, 32'hA5A5_0000 + 32'(i), 32'h0);
      endcase
    end

    send_request(CMD_INS_FRONT, 32'h1, 32'h0);
    send_request(CMD_INS_BACK, 32'h1, 32'h0);
    send_request(CMD_INS_AFTER, 32'h1, 32'h0);
    send_request(CMD_SEARCH, 32'd12, 32'h0);
    send_request(CMD_DEL_VALUE, 32'h0, 32'h0);
    send_request(CMD_DEL_VALUE, 32'h1234_5678, 32'h0);
    send_request(CMD_DEL_FRONT, 32'h0, 32'h0);
    send_request(CMD_DEL_BACK, 32'h0, 32'h0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // receiver holds off while requests keep coming
        if (phase == 0 && n == 60) hold_request = 1'b1;
        send_random_request();
      end
    end

    in_valid_i <= 1'b0;
    stall_pct = 0;
    while (book.expected_answers.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (book.mismatches == 0) $display("[bounded_ordered_list] OK");
    else $display("[bounded_ordered_list] ERROR");
    $finish;
  end

endmodule
